// File: sv/lcar_pkg.sv
package lcar_pkg;

    localparam int DATA_BITS = 24;
    localparam int NUM_CH    = 3;
    localparam int CH_W      = 2;
    localparam int GAP_W     = 16;
    localparam int TICK_W    = 10;
    localparam int BIT_W     = 5;
    localparam int WGT_W     = DATA_BITS + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 56;

    localparam logic [DATA_BITS-1:0] SIGN_FLIP = 24'h800000;
    localparam logic [BIT_W-1:0]     LAST_PULSE = BIT_W'(DATA_BITS + 1);

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_TARE  = 2'd1,
        MODE_WEIGH = 2'd2,
        MODE_ZERO  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 3'd0,
        CFG_GAP0   = 3'd1,
        CFG_GAP1   = 3'd2,
        CFG_GAP2   = 3'd3,
        CFG_HALF   = 3'd4
    } t_cfg_idx;

    // microprogram steps
    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_WAIT = 3'd1,
        ST_HIGH = 3'd2,
        ST_LOW  = 3'd3,
        ST_LAST = 3'd4
    } t_step;

    // condition that makes a step jump
    typedef enum logic [1:0] {
        CND_CMD  = 2'd0,
        CND_DLOW = 2'd1,
        CND_HALF = 2'd2
    } t_cond;

    // picks target b over target a on a jump
    typedef enum logic [1:0] {
        BR_NONE    = 2'd0,
        BR_LASTBIT = 2'd1,
        BR_NOMORE  = 2'd2
    } t_branch;

    typedef enum logic [1:0] {
        BIT_HOLD = 2'd0,
        BIT_ONE  = 2'd1,
        BIT_INC  = 2'd2,
        BIT_CLR  = 2'd3
    } t_bitop;

    typedef struct packed {
        t_cond   cond;
        t_branch br;
        t_step   tgt_a;
        t_step   tgt_b;
        logic    sck;
        logic    busy;
        logic    tick_run;
        logic    sample;
        t_bitop  bit_op;
        logic    begin_ch;
        logic    scan_next;
        logic    load_kind;
        logic    arm_div;
        logic    finish;
        logic    zero_ok;
    } t_uword;

    function automatic t_uword uc_rom(input t_step s);
        t_uword w;
        w = '{cond: CND_CMD, br: BR_NONE, tgt_a: ST_WAIT, tgt_b: ST_WAIT, sck: 1'b0,
              busy: 1'b0, tick_run: 1'b0, sample: 1'b0, bit_op: BIT_CLR,
              begin_ch: 1'b1, scan_next: 1'b0, load_kind: 1'b1, arm_div: 1'b0,
              finish: 1'b0, zero_ok: 1'b1};
        unique case (s)
            ST_IDLE: begin
            end
            ST_WAIT: begin
                w = '{cond: CND_DLOW, br: BR_NONE, tgt_a: ST_HIGH, tgt_b: ST_HIGH,
                      sck: 1'b0, busy: 1'b1, tick_run: 1'b0, sample: 1'b0,
                      bit_op: BIT_ONE, begin_ch: 1'b0, scan_next: 1'b0,
                      load_kind: 1'b0, arm_div: 1'b0, finish: 1'b0, zero_ok: 1'b0};
            end
            ST_HIGH: begin
                w = '{cond: CND_HALF, br: BR_LASTBIT, tgt_a: ST_LOW, tgt_b: ST_LAST,
                      sck: 1'b1, busy: 1'b1, tick_run: 1'b1, sample: 1'b0,
                      bit_op: BIT_HOLD, begin_ch: 1'b0, scan_next: 1'b0,
                      load_kind: 1'b0, arm_div: 1'b1, finish: 1'b0, zero_ok: 1'b0};
            end
            ST_LOW: begin
                w = '{cond: CND_HALF, br: BR_NONE, tgt_a: ST_HIGH, tgt_b: ST_HIGH,
                      sck: 1'b0, busy: 1'b1, tick_run: 1'b1, sample: 1'b1,
                      bit_op: BIT_INC, begin_ch: 1'b0, scan_next: 1'b0,
                      load_kind: 1'b0, arm_div: 1'b0, finish: 1'b0, zero_ok: 1'b0};
            end
            ST_LAST: begin
                w = '{cond: CND_HALF, br: BR_NOMORE, tgt_a: ST_WAIT, tgt_b: ST_IDLE,
                      sck: 1'b0, busy: 1'b1, tick_run: 1'b1, sample: 1'b0,
                      bit_op: BIT_CLR, begin_ch: 1'b1, scan_next: 1'b1,
                      load_kind: 1'b0, arm_div: 1'b0, finish: 1'b1, zero_ok: 1'b0};
            end
            default: begin
            end
        endcase
        return w;
    endfunction

endpackage

// File: sv/lcar_div.sv
module lcar_div
    import lcar_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [DATA_BITS-1:0]    i_mag,
    input  logic                    i_neg,
    input  logic [GAP_W-1:0]        i_den,
    output logic                    o_busy,
    output logic [WGT_W-1:0]        o_quo
);

    localparam int CNT_W = $clog2(DATA_BITS + 1);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [GAP_W-1:0]     r_rem;
    logic [DATA_BITS-1:0] r_quo;
    logic [GAP_W-1:0]     r_den;
    logic                 r_neg;

    logic [GAP_W:0]       trial;
    logic [GAP_W:0]       diff;
    logic                 fits;
    logic [WGT_W-1:0]     quo_ext;

    // shift-subtract, one quotient bit per cycle
    assign trial   = {r_rem, r_quo[DATA_BITS-1]};
    assign diff    = trial - {1'b0, r_den};
    assign fits    = trial >= {1'b0, r_den};
    assign quo_ext = {1'b0, r_quo};
    assign o_quo   = r_neg ? (~quo_ext + WGT_W'(1)) : quo_ext;
    assign o_busy  = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DATA_BITS);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_mag;
            r_neg <= i_neg;
            r_den <= (i_den == '0) ? GAP_W'(1) : i_den;
        end else if (r_busy) begin
            r_rem <= fits ? diff[GAP_W-1:0] : trial[GAP_W-1:0];
            r_quo <= {r_quo[DATA_BITS-2:0], fits};
        end
    end

endmodule

// File: sv/load_cell_adc_reader_top.sv
// Serial reader for three 24-bit bridge-sensor converters, driven by ticks: every input beat
// is one tick and yields exactly one output beat with the clock levels, the busy flag and,
// on the tick that ends a channel read, the count and weight. A tare or weigh command reads
// each enabled channel in ascending order; one read takes 25 sck pulses, each a high and a
// low half period of half_period_ticks ticks, plus the wait for the data line to go low.
// A small microprogram (one control word per step, five steps) sequences the reads. The
// weight quotient comes from a shift-subtract divider that starts as the 25th pulse falls;
// if the final tick of a read arrives before the quotient has settled, the input
// is held off until the quotient is ready, which can only happen when the final low half
// period ends before the division does, so with half periods below 25 ticks.
// Otherwise one beat is taken per clock cycle while the output register is free or drained.
module load_cell_adc_reader_top
    import lcar_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [S_DATA_W-1:0]     s_axis_tdata,   // zero_mask[2:0], dout_levels[5:3]
    input  logic [1:0]              s_axis_tuser,   // mode[1:0]
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // sck_levels[2:0], busy_res[3], result_channel[5:4], raw_count[29:6], weight[54:30]
    output logic [M_DATA_W-1:0]     m_axis_tdata,
    output logic [1:0]              m_axis_tuser,   // result_valid[0], result_kind[1]
    output logic                    m_axis_tlast,   // last
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DAT_W-1:0]    i_cfg_data
);

    // configuration
    logic [NUM_CH-1:0]    r_en;
    logic [GAP_W-1:0]     r_gap [NUM_CH];
    logic [TICK_W-1:0]    r_half;

    // sequencer and datapath
    t_step                r_step, n_step;
    logic [TICK_W-1:0]    r_tick, n_tick;
    logic [BIT_W-1:0]     r_bits, n_bits;
    logic [DATA_BITS-1:0] r_shift, n_shift;
    logic [CH_W-1:0]      r_ch, n_ch;
    logic                 r_kind, n_kind;
    logic [DATA_BITS-1:0] r_tare [NUM_CH];
    logic [DATA_BITS-1:0] n_tare [NUM_CH];

    // output register
    logic                 r_m_valid, n_m_valid;
    logic [M_DATA_W-1:0]  r_m_data, n_m_data;
    logic [1:0]           r_m_user, n_m_user;
    logic                 r_m_last, n_m_last;

    t_uword               uw;
    t_uword               uw_next;
    t_mode                mode;
    logic [NUM_CH-1:0]    zmask;
    logic [NUM_CH-1:0]    dout;
    logic                 dbit;
    logic                 half;
    logic [NUM_CH-1:0]    above;
    logic [NUM_CH-1:0]    cand;
    logic                 any_ch;
    logic [CH_W-1:0]      first_ch;
    logic                 cond_true;
    logic                 br_sel;
    t_step                jump_step;
    logic                 accept;
    logic                 stall;
    logic [DATA_BITS-1:0] raw;
    logic [DATA_BITS-1:0] tare_cur;
    logic                 d_neg;
    logic [DATA_BITS-1:0] d_mag;
    logic                 div_start;
    logic                 div_busy;
    logic [WGT_W-1:0]     div_quo;
    logic                 fin;
    logic [NUM_CH-1:0]    n_sck;
    logic [WGT_W-1:0]     res_weight;
    logic [DATA_BITS-1:0] res_raw;

    assign mode  = t_mode'(s_axis_tuser);
    assign zmask = s_axis_tdata[NUM_CH-1:0];
    assign dout  = s_axis_tdata[2*NUM_CH-1:NUM_CH];
    assign dbit  = dout[r_ch];

    assign uw    = uc_rom(r_step);
    assign half  = ({1'b0, r_tick} + (TICK_W+1)'(1)) >= {1'b0, r_half};

    assign raw      = r_shift ^ SIGN_FLIP;
    assign tare_cur = r_tare[r_ch];
    assign d_neg    = raw < tare_cur;
    assign d_mag    = d_neg ? (tare_cur - raw) : (raw - tare_cur);

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            above[c] = !uw.scan_next || (CH_W'(c) > r_ch);
        end
        cand     = r_en & above;
        any_ch   = |cand;
        first_ch = '0;
        for (int c = NUM_CH - 1; c >= 0; c--) begin
            if (cand[c]) begin
                first_ch = CH_W'(c);
            end
        end
    end

    always_comb begin
        unique case (uw.cond)
            CND_CMD:  cond_true = ((mode == MODE_TARE) || (mode == MODE_WEIGH)) && any_ch;
            CND_DLOW: cond_true = !dbit;
            CND_HALF: cond_true = half;
            default:  cond_true = 1'b0;
        endcase
        unique case (uw.br)
            BR_NONE:    br_sel = 1'b0;
            BR_LASTBIT: br_sel = (r_bits == LAST_PULSE);
            BR_NOMORE:  br_sel = !any_ch;
            default:    br_sel = 1'b0;
        endcase
        jump_step = br_sel ? uw.tgt_b : uw.tgt_a;
    end

    // hold the final tick of a weigh read until the quotient has settled
    assign stall         = uw.finish && half && div_busy;
    assign s_axis_tready = i_rst_n && (!r_m_valid || m_axis_tready) && !stall;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign fin           = accept && cond_true && uw.finish;
    assign div_start     = accept && cond_true && uw.arm_div && br_sel && r_kind;

    lcar_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (d_mag),
        .i_neg   (d_neg),
        .i_den   (r_gap[r_ch]),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_step    = r_step;
        n_tick    = r_tick;
        n_bits    = r_bits;
        n_shift   = r_shift;
        n_ch      = r_ch;
        n_kind    = r_kind;
        n_tare    = r_tare;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        n_m_last  = r_m_last;

        if (accept) begin
            if (uw.sample && (r_tick == '0)) begin
                n_shift = {r_shift[DATA_BITS-2:0], dbit};
            end
            if (cond_true) begin
                n_step = jump_step;
                n_tick = '0;
                unique case (uw.bit_op)
                    BIT_HOLD: n_bits = r_bits;
                    BIT_ONE:  n_bits = BIT_W'(1);
                    BIT_INC:  n_bits = r_bits + BIT_W'(1);
                    BIT_CLR:  n_bits = '0;
                    default:  n_bits = r_bits;
                endcase
                if (uw.begin_ch) begin
                    n_shift = '0;
                    if (any_ch) begin
                        n_ch = first_ch;
                    end
                end
                if (uw.load_kind) begin
                    n_kind = (mode == MODE_WEIGH);
                end
                if (uw.finish && !r_kind) begin
                    n_tare[r_ch] = raw;
                end
            end else if (uw.tick_run) begin
                n_tick = r_tick + TICK_W'(1);
            end
            if (uw.zero_ok && (mode == MODE_ZERO)) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    if (zmask[c]) begin
                        n_tare[c] = '0;
                    end
                end
            end
        end

        uw_next    = uc_rom(n_step);
        n_sck      = uw_next.sck ? (NUM_CH'(1) << n_ch) : '0;
        res_raw    = fin ? raw : '0;
        res_weight = (fin && r_kind) ? div_quo : '0;

        if (accept) begin
            n_m_valid = 1'b1;
            n_m_data  = {1'b0, res_weight, res_raw, (fin ? r_ch : CH_W'(0)),
                         uw_next.busy, n_sck};
            n_m_user  = {fin && r_kind, fin};
            n_m_last  = fin && !any_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= ST_IDLE;
            r_tick    <= '0;
            r_bits    <= '0;
            r_ch      <= '0;
            r_kind    <= 1'b0;
            r_m_valid <= 1'b0;
            for (int c = 0; c < NUM_CH; c++) begin
                r_tare[c] <= '0;
            end
        end else begin
            r_step    <= n_step;
            r_tick    <= n_tick;
            r_bits    <= n_bits;
            r_ch      <= n_ch;
            r_kind    <= n_kind;
            r_m_valid <= n_m_valid;
            r_tare    <= n_tare;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift  <= n_shift;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
        r_m_last <= n_m_last;
    end

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en   <= NUM_CH'(7);
            r_half <= TICK_W'(168);
            for (int c = 0; c < NUM_CH; c++) begin
                r_gap[c] <= GAP_W'(1);
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ENABLE: r_en     <= i_cfg_data[NUM_CH-1:0];
                CFG_GAP0:   r_gap[0] <= i_cfg_data[GAP_W-1:0];
                CFG_GAP1:   r_gap[1] <= i_cfg_data[GAP_W-1:0];
                CFG_GAP2:   r_gap[2] <= i_cfg_data[GAP_W-1:0];
                CFG_HALF:   r_half   <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tlast  = r_m_last;

endmodule

// File: sv/lcar_chk.sv
module lcar_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_sck: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tdata[2:0])
            && (m_axis_tdata[3] || (m_axis_tdata[2:0] == 3'd0)))
        else $error("clock driven while idle or on several channels");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0] && !m_axis_tdata[3])
        else $error("last beat without a result or while still busy");

    a_tare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] && !m_axis_tuser[1] |-> m_axis_tdata[54:30] == 25'd0)
        else $error("tare result carries a weight");

endmodule

bind load_cell_adc_reader_top lcar_chk u_lcar_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/load_cell_adc_reader_top_test.sv
module load_cell_adc_reader_top_test;
    import lcar_pkg::*;

    localparam int STUCK_LIMIT = 4000;  // cycles without any beat before giving up
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int SETTLE      = 40;    // divider and output register margin
    localparam int MAX_REPORTS = 200;
    localparam int ITEMS       = 1650;  // input beats to send, roughly

    typedef enum int {
        PH_IDLE,
        PH_WAIT,
        PH_HIGH,
        PH_LOW
    } t_reader_phase;

    // what the data line of the channel under read carries
    typedef enum int {
        DAT_NOISE,
        DAT_ONES,
        DAT_ZEROS,
        DAT_FLOOR,
        DAT_CEIL
    } t_data_pat;

    typedef struct packed {
        t_mode      mode;
        logic [2:0] zmask;
        logic [2:0] dout;
    } t_tick;

    typedef struct packed {
        logic [2:0]  sck;
        logic        busy;
        logic        done;
        logic [1:0]  ch;
        logic        kind;
        logic [23:0] raw;
        logic [24:0] weight;
        logic        last;
    } t_reading;

    class cell_reading_book;
        logic [2:0]    en_mask;
        logic [15:0]   gap [NUM_CH];
        int            half;
        logic [23:0]   tare_cnt [NUM_CH];
        logic [23:0]   raw_cnt [NUM_CH];
        logic [24:0]   wgt [NUM_CH];
        logic [23:0]   shreg;
        int            nbit;
        int            ticks;
        t_reader_phase ph;
        int            cur_ch;
        logic          weighing;
        t_reading      due_readings[$];
        int            errors;
        int            reads;
        int            weighs;
        int            ticks_seen;

        function new();
            en_mask = 3'b111;
            half = 168;
            for (int c = 0; c < NUM_CH; c++) begin
                gap[c] = 16'd1;
                tare_cnt[c] = '0;
                raw_cnt[c] = '0;
                wgt[c] = '0;
            end
            shreg = '0;
            nbit = 0;
            ticks = 0;
            ph = PH_IDLE;
            cur_ch = 0;
            weighing = 1'b0;
            errors = 0;
            reads = 0;
            weighs = 0;
            ticks_seen = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [15:0] val);
            case (idx)
                CFG_ENABLE: en_mask = val[2:0];
                CFG_GAP0:   gap[0] = val;
                CFG_GAP1:   gap[1] = val;
                CFG_GAP2:   gap[2] = val;
                CFG_HALF:   half = int'(val[9:0]);
                default: ;
            endcase
        endfunction

        function bit busy();
            return ph != PH_IDLE;
        endfunction

        function int first_enabled(int from);
            for (int c = from; c < NUM_CH; c++) begin
                if (en_mask[c]) return c;
            end
            return NUM_CH;
        endfunction

        function void start_channel(int c);
            cur_ch = c;
            shreg = '0;
            nbit = 0;
            ticks = 0;
            ph = PH_WAIT;
        endfunction

        function void take_tick(t_tick t);
            t_reading    r;
            logic        dbit;
            logic [23:0] cnt;
            int          ch;
            int          c;
            int          g;
            int          delta;
            int          q;
            r = '0;
            ch = cur_ch;
            dbit = t.dout[ch];
            ticks_seen++;
            case (ph)
                PH_IDLE: begin
                    if (t.mode == MODE_TARE || t.mode == MODE_WEIGH) begin
                        c = first_enabled(0);
                        if (c < NUM_CH) begin
                            weighing = (t.mode == MODE_WEIGH);
                            start_channel(c);
                        end
                    end else if (t.mode == MODE_ZERO) begin
                        for (c = 0; c < NUM_CH; c++) begin
                            if (t.zmask[c]) begin
                                tare_cnt[c] = '0;
                                raw_cnt[c] = '0;
                                wgt[c] = '0;
                            end
                        end
                    end
                end
                PH_WAIT: begin
                    if (!dbit) begin
                        ph = PH_HIGH;
                        ticks = 0;
                        nbit = 1;
                    end
                end
                PH_HIGH: begin
                    if (ticks + 1 >= half) begin
                        ph = PH_LOW;
                        ticks = 0;
                    end else begin
                        ticks++;
                    end
                end
                PH_LOW: begin
                    // sample on the first low tick of each data pulse
                    if (ticks == 0 && nbit <= DATA_BITS) shreg = {shreg[22:0], dbit};
                    if (ticks + 1 < half) begin
                        ticks++;
                    end else if (nbit <= DATA_BITS) begin
                        ph = PH_HIGH;
                        ticks = 0;
                        nbit++;
                    end else begin
                        cnt = shreg ^ SIGN_FLIP;
                        r.done = 1'b1;
                        r.ch = 2'(ch);
                        r.kind = weighing;
                        r.raw = cnt;
                        reads++;
                        if (!weighing) begin
                            tare_cnt[ch] = cnt;
                        end else begin
                            g = (gap[ch] == 16'd0) ? 1 : int'(gap[ch]);
                            delta = int'({8'd0, cnt}) - int'({8'd0, tare_cnt[ch]});
                            q = delta / g;
                            raw_cnt[ch] = cnt;
                            wgt[ch] = q[24:0];
                            r.weight = q[24:0];
                            weighs++;
                        end
                        c = first_enabled(ch + 1);
                        if (c < NUM_CH) begin
                            start_channel(c);
                        end else begin
                            r.last = 1'b1;
                            ph = PH_IDLE;
                            ticks = 0;
                            nbit = 0;
                        end
                    end
                end
                default: ;
            endcase
            if (ph == PH_HIGH) r.sck = 3'(1 << cur_ch);
            r.busy = (ph != PH_IDLE);
            due_readings.push_back(r);
        endfunction

        function void cmp(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                if (errors < MAX_REPORTS)
                    $error("%s expected 0x%0h got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void match_beat(logic [M_DATA_W-1:0] d, logic [1:0] u, logic l);
            t_reading w;
            if (due_readings.size() == 0) begin
                $error("output beat with no reading due");
                errors++;
                return;
            end
            w = due_readings.pop_front();
            cmp("sck_levels", 32'(w.sck), 32'(d[2:0]));
            cmp("busy_res", 32'(w.busy), 32'(d[3]));
            cmp("result_valid", 32'(w.done), 32'(u[0]));
            cmp("result_channel", 32'(w.ch), 32'(d[5:4]));
            cmp("result_kind", 32'(w.kind), 32'(u[1]));
            cmp("raw_count", 32'(w.raw), 32'(d[29:6]));
            cmp("weight", 32'(w.weight), 32'(d[54:30]));
            cmp("last", 32'(w.last), 32'(l));
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata = '0;   // zero_mask[2:0], dout_levels[5:3]
    logic [1:0]           s_axis_tuser = MODE_TICK;   // mode[1:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // sck_levels[2:0], busy_res[3], result_channel[5:4], raw_count[29:6], weight[54:30]
    logic [M_DATA_W-1:0]  m_axis_tdata;
    logic [1:0]           m_axis_tuser;   // result_valid[0], result_kind[1]
    logic                 m_axis_tlast;   // last
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_ENABLE;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    cell_reading_book book = new();
    bit tx_lazy = 1'b1;
    bit rx_lazy = 1'b1;
    bit hold_out = 1'b0;
    int cfg_writes = 0;
    int stuck = 0;

    load_cell_adc_reader_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
            if (stuck >= STUCK_LIMIT) begin
                $display("load_cell_adc_reader_top verification failed");
                $finish;
            end
        end
    end

    // output side: random stalls per beat, one long hold-off on request
    initial begin
        int stall;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = rx_lazy ? $urandom_range(0, 11) : 0;
            if (hold_out) begin
                stall = HOLD_CYCLES;
                hold_out = 1'b0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            book.match_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // level of the channel under read follows the pattern; the rest is noise
    function automatic logic [2:0] pick_dout(t_data_pat pat);
        logic [2:0] d;
        logic       b;
        d = 3'($urandom);
        case (pat)
            DAT_ONES:  b = 1'b1;
            DAT_ZEROS: b = 1'b0;
            DAT_FLOOR: b = (book.nbit == 1);
            DAT_CEIL:  b = (book.nbit != 1);
            default:   b = 1'($urandom);
        endcase
        // keep the converter not ready for a few ticks
        if (book.ph == PH_WAIT) b = ($urandom_range(0, 3) != 0);
        if (book.ph != PH_IDLE) d[book.cur_ch] = b;
        return d;
    endfunction

    task automatic send_tick(t_mode m, logic [2:0] zm, t_data_pat pat);
        int         gap;
        t_tick      t;
        gap = tx_lazy ? $urandom_range(0, 11) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        t.mode = m;
        t.zmask = zm;
        t.dout = pick_dout(pat);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= m;
        s_axis_tdata <= {2'b00, t.dout, t.zmask};
        do @(posedge i_clk); while (!s_axis_tready);
        book.take_tick(t);
    endtask

    // issue one command and clock it to the end, with ignored commands mixed in
    task automatic run_command(t_mode m, logic [2:0] zm, t_data_pat pat);
        send_tick(m, zm, pat);
        while (book.busy()) begin
            if ($urandom_range(0, 9) == 0)
                send_tick(t_mode'($urandom_range(1, 3)), 3'($urandom), pat);
            else
                send_tick(MODE_TICK, 3'($urandom), pat);
        end
    endtask

    task automatic drain_and_pause();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (book.due_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        book.write_reg(idx, val);
        cfg_writes++;
    endtask

    task automatic cfg_close();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_gap();
        case ($urandom_range(0, 3))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 255));
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    initial begin
        int        phases;
        int        sel;
        t_data_pat pat;
        phases = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // shortest half period, full-scale counts of both signs, gap of zero
        write_reg(CFG_ENABLE, 16'd7);
        write_reg(CFG_GAP0, 16'd1);
        write_reg(CFG_GAP1, 16'hFFFF);
        write_reg(CFG_GAP2, 16'd0);
        write_reg(CFG_HALF, 16'd0);
        cfg_close();
        run_command(MODE_ZERO, 3'b111, DAT_NOISE);
        run_command(MODE_TARE, 3'b000, DAT_CEIL);
        run_command(MODE_WEIGH, 3'b000, DAT_FLOOR);
        run_command(MODE_ZERO, 3'b101, DAT_NOISE);
        run_command(MODE_WEIGH, 3'b000, DAT_CEIL);
        run_command(MODE_TARE, 3'b010, DAT_ONES);
        run_command(MODE_WEIGH, 3'b101, DAT_ZEROS);
        run_command(MODE_TICK, 3'b111, DAT_NOISE);
        drain_and_pause();

        // nothing enabled: tare and weigh stay idle
        write_reg(CFG_ENABLE, 16'd0);
        write_reg(CFG_HALF, 16'd1);
        cfg_close();
        run_command(MODE_TARE, 3'b000, DAT_NOISE);
        run_command(MODE_WEIGH, 3'b000, DAT_NOISE);
        run_command(MODE_ZERO, 3'b111, DAT_NOISE);
        drain_and_pause();

        // back up the output so the block must stall its input
        write_reg(CFG_ENABLE, 16'd5);
        write_reg(CFG_GAP2, 16'd7);
        cfg_close();
        hold_out = 1'b1;
        run_command(MODE_WEIGH, 3'b000, DAT_NOISE);
        run_command(MODE_TARE, 3'b000, DAT_NOISE);
        drain_and_pause();

        // one channel, no idling, quotient still settling at the final tick
        write_reg(CFG_ENABLE, 16'd2);
        write_reg(CFG_GAP1, 16'd300);
        write_reg(CFG_HALF, 16'd2);
        cfg_close();
        tx_lazy = 1'b0;
        rx_lazy = 1'b0;
        run_command(MODE_WEIGH, 3'b000, DAT_NOISE);
        drain_and_pause();

        while (book.ticks_seen < ITEMS) begin
            phases++;
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_ENABLE, 16'd0);
            else if ($urandom_range(0, 1) == 0)
                write_reg(CFG_ENABLE, 16'($urandom_range(1, 7)));
            if ($urandom_range(0, 1) == 0) write_reg(CFG_GAP0, pick_gap());
            if ($urandom_range(0, 1) == 0) write_reg(CFG_GAP1, pick_gap());
            if ($urandom_range(0, 1) == 0) write_reg(CFG_GAP2, pick_gap());
            write_reg(CFG_HALF, 16'($urandom_range(0, 4)));
            cfg_close();
            tx_lazy = ($urandom_range(0, 3) != 0);
            rx_lazy = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 3)) begin
                if (book.ticks_seen < ITEMS) begin
                    sel = $urandom_range(0, 19);
                    pat = ($urandom_range(0, 2) == 0) ? t_data_pat'($urandom_range(0, 4))
                                                      : DAT_NOISE;
                    if (sel < 7)
                        run_command(MODE_TARE, 3'($urandom), pat);
                    else if (sel < 16)
                        run_command(MODE_WEIGH, 3'($urandom), pat);
                    else if (sel < 18)
                        run_command(MODE_ZERO, 3'($urandom), pat);
                    else
                        repeat ($urandom_range(1, 20))
                            send_tick(MODE_TICK, 3'($urandom), DAT_NOISE);
                end
            end
            drain_and_pause();
        end

        $display("Clocked %0d ticks through %0d random setting phases and %0d register writes.",
                 book.ticks_seen, phases, cfg_writes);
        $display("Finished %0d channel reads, %0d of them weighs.", book.reads, book.weighs);
        if (book.errors == 0 && book.due_readings.size() == 0) begin
            $display("load_cell_adc_reader_top verification clean");
        end else begin
            $display("load_cell_adc_reader_top verification failed");
        end
        $finish;
    end

endmodule
